FILE: hdl/ptsrob_pkg.sv
package ptsrob_pkg;

	localparam int DEPTH    = 8;
	localparam int PTS_BITS = 33;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int FIELD_PTS_W = 33;
	localparam int TAG_W    = 8;
	localparam int PRIME_W  = 4;
	localparam int FILL_W   = 4;
	localparam int ENTRY_W  = PTS_BITS + TAG_W;
	localparam int CMP_W    = (CNT_W > PRIME_W) ? CNT_W : PRIME_W;
	localparam int PADDR_W  = 3;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [PTS_BITS-1:0] PTS_SENTINEL = PTS_BITS'(24'hFFFFFF);
	localparam logic [PRIME_W-1:0]  PRIME_RESET  = 4'd8;
	localparam logic [REG_IDX_W-1:0] REG_PRIME   = '0;

	typedef enum logic {
		MODE_PUSH,
		MODE_POP
	} mode_t;

	typedef enum logic [1:0] {
		ST_PUSHED,
		ST_POPPED,
		ST_POP_REFUSED,
		ST_PUSH_FULL
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_RD,
		S_SHIFT,
		S_SCAN_START,
		S_SCAN
	} ctrl_state_t;

	typedef struct packed {
		mode_t                  mode;
		logic [FIELD_PTS_W-1:0] entry_pts;
		logic [TAG_W-1:0]       entry_tag;
	} item_t;

	typedef struct packed {
		status_t                status;
		logic [FIELD_PTS_W-1:0] out_pts;
		logic [TAG_W-1:0]       out_tag;
		logic [FILL_W-1:0]      fill_count;
	} result_t;

	typedef struct packed {
		logic    push_wr;
		logic    pop_start;
		logic    pop_take;
		logic    shift_step;
		logic    scan_init;
		logic    scan_step;
		logic    emit;
		status_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic             full;
		logic             empty;
		logic             more;
		logic [CNT_W-1:0] count;
	} dp_stat_t;

endpackage

FILE: hdl/ptsrob_ram.sv
module ptsrob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/ptsrob_ctrl.sv
module ptsrob_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  ptsrob_pkg::mode_t             mode,
	input  logic [ptsrob_pkg::PRIME_W-1:0] prime_count,
	input  ptsrob_pkg::dp_stat_t          stat,
	output ptsrob_pkg::dp_cmd_t           cmd,
	output logic                          busy
);

	import ptsrob_pkg::*;

	ctrl_state_t      state_q, state_d;
	logic             priming_q, priming_d;
	logic [CMP_W-1:0] need;
	logic [CMP_W-1:0] cnt_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			priming_q <= 1'b1;
		end else begin
			state_q   <= state_d;
			priming_q <= priming_d;
		end
	end

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		priming_d = priming_q;
		cnt_ext   = CMP_W'(stat.count);
		need      = (CMP_W'(prime_count) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
		                                                   : CMP_W'(prime_count);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (mode == MODE_PUSH) begin
						cmd.emit = 1'b1;
						if (stat.full) begin
							cmd.code = ST_PUSH_FULL;
						end else begin
							cmd.push_wr = 1'b1;
							cmd.code    = ST_PUSHED;
						end
					end else if (stat.empty || (priming_q && (cnt_ext < need))) begin
						cmd.emit = 1'b1;
						cmd.code = ST_POP_REFUSED;
					end else begin
						cmd.pop_start = 1'b1;
						priming_d     = 1'b0;
						state_d       = S_POP_RD;
					end
				end
			end
			S_POP_RD: begin
				cmd.pop_take = 1'b1;
				state_d      = stat.more ? S_SHIFT : S_SCAN_START;
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (!stat.more) begin
					state_d = S_SCAN_START;
				end
			end
			S_SCAN_START: begin
				cmd.scan_init = 1'b1;
				if (stat.empty) begin
					cmd.emit = 1'b1;
					cmd.code = ST_POPPED;
					state_d  = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (!stat.more) begin
					cmd.emit = 1'b1;
					cmd.code = ST_POPPED;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: hdl/ptsrob_dp.sv
module ptsrob_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptsrob_pkg::item_t    item,
	input  ptsrob_pkg::dp_cmd_t  cmd,
	output ptsrob_pkg::dp_stat_t stat,
	output logic                 done,
	output ptsrob_pkg::result_t  result
);

	import ptsrob_pkg::*;

	logic [CNT_W-1:0]    count_q;
	logic [ADDR_W-1:0]   best_slot_q;
	logic [PTS_BITS-1:0] best_pts_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [PTS_BITS-1:0] hold_pts_q;
	logic [TAG_W-1:0]    hold_tag_q;
	logic                done_q;
	result_t             result_q;

	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [ENTRY_W-1:0]  wdata;
	logic [ADDR_W-1:0]   raddr;
	logic [ENTRY_W-1:0]  rdata;

	logic [PTS_BITS-1:0] in_pts;
	logic [PTS_BITS-1:0] rd_pts;
	logic [TAG_W-1:0]    rd_tag;
	logic [CNT_W-1:0]    idx_ext;
	logic [CNT_W-1:0]    idx_p1;
	logic [CNT_W-1:0]    count_p1;

	ptsrob_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign in_pts   = PTS_BITS'(item.entry_pts);
	assign rd_pts   = rdata[ENTRY_W-1:TAG_W];
	assign rd_tag   = rdata[TAG_W-1:0];
	assign idx_ext  = CNT_W'(idx_q);
	assign idx_p1   = idx_ext + CNT_W'(1);
	assign count_p1 = count_q + CNT_W'(1);

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.more  = (idx_p1 < count_q);
	assign stat.count = count_q;

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata;
		raddr = idx_q;
		if (cmd.push_wr) begin
			we    = 1'b1;
			waddr = ADDR_W'(count_q);
			wdata = {in_pts, item.entry_tag};
		end
		if (cmd.shift_step) begin
			we    = 1'b1;
			waddr = idx_q;
			wdata = rdata;
		end
		if (cmd.pop_start) begin
			raddr = best_slot_q;
		end else if (cmd.pop_take || cmd.scan_step) begin
			raddr = ADDR_W'(idx_p1);
		end else if (cmd.shift_step) begin
			raddr = ADDR_W'(idx_ext + CNT_W'(2));
		end else if (cmd.scan_init) begin
			raddr = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			best_slot_q <= '0;
			best_pts_q  <= PTS_SENTINEL;
			idx_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.push_wr) begin
				count_q <= count_p1;
				if (in_pts < best_pts_q) begin
					best_slot_q <= ADDR_W'(count_q);
					best_pts_q  <= in_pts;
				end
			end
			if (cmd.pop_start) begin
				idx_q <= best_slot_q;
			end
			if (cmd.pop_take) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.shift_step) begin
				idx_q <= ADDR_W'(idx_p1);
			end
			if (cmd.scan_init) begin
				idx_q       <= '0;
				best_slot_q <= '0;
				best_pts_q  <= PTS_SENTINEL;
			end
			if (cmd.scan_step) begin
				idx_q <= ADDR_W'(idx_p1);
				if (rd_pts < best_pts_q) begin
					best_slot_q <= idx_q;
					best_pts_q  <= rd_pts;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_take) begin
			hold_pts_q <= rd_pts;
			hold_tag_q <= rd_tag;
		end
		if (cmd.emit) begin
			result_q.status     <= cmd.code;
			result_q.out_pts    <= (cmd.code == ST_POPPED) ? FIELD_PTS_W'(hold_pts_q) : '0;
			result_q.out_tag    <= (cmd.code == ST_POPPED) ? hold_tag_q : '0;
			result_q.fill_count <= cmd.push_wr ? FILL_W'(count_p1) : FILL_W'(count_q);
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |-> (count_q != CNT_W'(DEPTH)))
		else $error("push written into a full buffer");

	a_pop_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_start |-> (CNT_W'(best_slot_q) < count_q))
		else $error("pop selects a slot outside the held entries");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |=> (count_q == CNT_W'($past(count_q) + CNT_W'(1))))
		else $error("entry count did not advance on push");
`endif

endmodule

FILE: hdl/pts_reorder_buffer_unit.sv
// channel   | signals                                  | beat taken when
// ----------+------------------------------------------+------------------------------
// command   | start, busy, item                        | start high, busy low
// result    | done, result                             | done high (one cycle, no stall)
// config    | psel, penable, pwrite, paddr, pwdata,    | psel, penable, pwrite, pready
//           | prdata, pready                           |
// push and refused beats: result in the cycle after the command beat
// pop: read the selected slot, shift the entries above it down, then a minimum scan over the
//   remaining entries through the slot memory
// busy stays high through a pop; reset clears counts and restarts priming, slot memory is not cleared
// results cannot be held off: each beat is shown for exactly one cycle
module pts_reorder_buffer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ptsrob_pkg::item_t             item,
	output logic                          done,
	output ptsrob_pkg::result_t           result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ptsrob_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	import ptsrob_pkg::*;

	logic [PRIME_W-1:0] prime_q;
	logic               sel_prime;
	dp_cmd_t            cmd;
	dp_stat_t           stat;

	assign pready    = 1'b1;
	assign sel_prime = (paddr[PADDR_W-1:2] == REG_PRIME);
	assign prdata    = sel_prime ? 32'(prime_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= PRIME_RESET;
		end else if (psel && penable && pwrite && pready && sel_prime) begin
			prime_q <= pwdata[PRIME_W-1:0];
		end
	end

	ptsrob_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.mode       (item.mode),
		.prime_count(prime_q),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy)
	);

	ptsrob_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.stat  (stat),
		.done  (done),
		.result(result)
	);

endmodule

FILE: bench/testbench.sv
module testbench;
	import ptsrob_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int POP_LATENCY_MAX = 2 * DEPTH + 1;
	localparam int PHASE_ITEMS     = 245;
	localparam logic [PADDR_W-1:0] PRIME_ADDR = {REG_PRIME, 2'b00};

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                start   = 1'b0;
	logic                busy;
	item_t               cmd     = '0;
	logic                done;
	result_t             res;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [PADDR_W-1:0]  paddr   = '0;
	logic [31:0]         pwdata  = '0;
	logic [31:0]         prdata;
	logic                pready;

	// expected buffer contents, oldest first
	logic [FIELD_PTS_W-1:0] rob_pts[$];
	logic [TAG_W-1:0]       rob_tag[$];
	bit                     still_priming = 1'b1;
	logic [PRIME_W-1:0]     prime_cfg     = PRIME_RESET;
	result_t                pending_results[$];

	bit idle_on = 1'b1;
	int error_count = 0;
	int quiet_cycles = 0;
	int n_pushed = 0;
	int n_popped = 0;
	int n_pop_refused = 0;
	int n_push_full = 0;
	int n_prime_writes = 0;

	pts_reorder_buffer_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (cmd),
		.done    (done),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic result_t compute_outcome(item_t it);
		result_t r;
		int need;
		int k;
		logic [FIELD_PTS_W-1:0] lowest;
		r = '0;
		if (it.mode == MODE_PUSH) begin
			if (rob_pts.size() >= DEPTH) begin
				r.status = ST_PUSH_FULL;
			end else begin
				rob_pts = {rob_pts, it.entry_pts};
				rob_tag = {rob_tag, it.entry_tag};
				r.status = ST_PUSHED;
			end
		end else begin
			need = (prime_cfg > DEPTH) ? DEPTH : int'(prime_cfg);
			if (rob_pts.size() == 0 || (still_priming && rob_pts.size() < need)) begin
				r.status = ST_POP_REFUSED;
			end else begin
				// lowest below the sentinel wins, first one on ties, else the oldest
				k = 0;
				lowest = PTS_SENTINEL;
				for (int i = 0; i < rob_pts.size(); i++) begin
					if (rob_pts[i] < lowest) begin
						lowest = rob_pts[i];
						k = i;
					end
				end
				r.out_pts = rob_pts[k];
				r.out_tag = rob_tag[k];
				rob_pts.delete(k);
				rob_tag.delete(k);
				still_priming = 1'b0;
				r.status = ST_POPPED;
			end
		end
		r.fill_count = FILL_W'(rob_pts.size());
		return r;
	endfunction

	function automatic logic [FIELD_PTS_W-1:0] random_pts();
		case ($urandom_range(0, 9))
			0, 1, 2: return FIELD_PTS_W'($urandom_range(0, 15));
			3, 4:    return FIELD_PTS_W'(PTS_SENTINEL - 8 + $urandom_range(0, 16));
			5:       return $urandom_range(0, 1) ? PTS_SENTINEL : '1;
			6, 7:    return FIELD_PTS_W'({$urandom, $urandom});
			default: return FIELD_PTS_W'($urandom_range(0, 24'hFFFFFF));
		endcase
	endfunction

	task automatic send_item(item_t it);
		int gap;
		result_t want_r;
		gap = 0;
		if (idle_on && $urandom_range(0, 2) == 0)
			gap = $urandom_range(1, 11);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= it;
		do @(posedge clk); while (busy);
		want_r = compute_outcome(it);
		pending_results = {pending_results, want_r};
	endtask

	task automatic push(logic [FIELD_PTS_W-1:0] p, logic [TAG_W-1:0] t);
		item_t it;
		it.mode = MODE_PUSH;
		it.entry_pts = p;
		it.entry_tag = t;
		send_item(it);
	endtask

	task automatic pop();
		item_t it;
		it.mode = MODE_POP;
		it.entry_pts = random_pts();
		it.entry_tag = TAG_W'($urandom);
		send_item(it);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0 || busy) @(posedge clk);
	endtask

	// leaves psel and penable high; check_prime_readback drops them afterwards
	task automatic apb_access(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PRIME_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
	endtask

	task automatic check_prime_readback();
		logic [31:0] rd;
		apb_access(1'b0, '0, rd);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd[PRIME_W-1:0] !== prime_cfg) begin
			$error("prime_count expected %0d got %0d", prime_cfg, rd[PRIME_W-1:0]);
			error_count++;
		end
	endtask

	task automatic program_prime(logic [PRIME_W-1:0] v);
		logic [31:0] rd;
		wait_drained();
		apb_access(1'b1, {28'($urandom), v}, rd);
		prime_cfg = v;
		n_prime_writes++;
		check_prime_readback();
	endtask

	// pops held off until the reset priming count is reached, then full and empty
	task automatic test_priming();
		check_prime_readback();
		pop();
		push('1, 8'hFF);
		push(PTS_SENTINEL, 8'h00);
		push(FIELD_PTS_W'(24'hFFFFFE), 8'hA5);
		push('0, 8'h5A);
		push('0, 8'hC3);
		push(FIELD_PTS_W'(33'h1_2345_6789), 8'h3C);
		push(FIELD_PTS_W'(33'h1_0000_0000), 8'h81);
		pop();
		push(FIELD_PTS_W'(20'hABCDE), 8'h7E);
		push(FIELD_PTS_W'(5), 8'h01);
		repeat (DEPTH + 1) pop();
		wait_drained();
	endtask

	task automatic test_sentinel_and_ties();
		program_prime(4'd1);
		push(FIELD_PTS_W'(25'h100_0000), 8'h11);
		push(PTS_SENTINEL, 8'h22);
		push('1, 8'h33);
		pop();
		push(FIELD_PTS_W'(7), 8'h44);
		push(FIELD_PTS_W'(7), 8'h55);
		repeat (5) pop();
		wait_drained();
	endtask

	task automatic test_random_traffic();
		logic [PRIME_W-1:0] prime_set[6] = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd8};
		int push_pct[6] = '{50, 65, 35, 50, 55, 50};
		item_t it;
		for (int ph = 0; ph < 6; ph++) begin
			program_prime(ph == 4 ? PRIME_W'($urandom) : prime_set[ph]);
			idle_on = (ph != 2) && (ph != 5);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				it.mode = ($urandom_range(0, 99) < push_pct[ph]) ? MODE_PUSH : MODE_POP;
				it.entry_pts = random_pts();
				it.entry_tag = TAG_W'($urandom);
				send_item(it);
			end
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no command outstanding");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				case (want.status)
					ST_PUSHED:      n_pushed++;
					ST_POPPED:      n_popped++;
					ST_POP_REFUSED: n_pop_refused++;
					ST_PUSH_FULL:   n_push_full++;
				endcase
				if (res.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, res.status);
					error_count++;
				end
				if (res.out_pts !== want.out_pts) begin
					$error("out_pts expected %0h got %0h", want.out_pts, res.out_pts);
					error_count++;
				end
				if (res.out_tag !== want.out_tag) begin
					$error("out_tag expected %0h got %0h", want.out_tag, res.out_tag);
					error_count++;
				end
				if (res.fill_count !== want.fill_count) begin
					$error("fill_count expected %0d got %0d", want.fill_count, res.fill_count);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_priming();
		test_sentinel_and_ties();
		test_random_traffic();
		wait_drained();
		repeat (POP_LATENCY_MAX + 4) @(posedge clk);
		$display("tb: checked %0d pushes, %0d pops, %0d refused pops, %0d pushes into a full buffer",
			n_pushed, n_popped, n_pop_refused, n_push_full);
		$display("tb: %0d prime_count settings incl. 0, 1, 8 and 15, sentinel and tie ordering",
			n_prime_writes);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/ptsrob_pkg.sv
hdl/ptsrob_ram.sv
hdl/ptsrob_ctrl.sv
hdl/ptsrob_dp.sv
hdl/pts_reorder_buffer_unit.sv
bench/testbench.sv
